FILE: rtl/stt_pkg.sv
// Package for the source text tokenizer: item types, codes, keyword tables and helpers.
package stt_pkg;

  localparam logic [7:0]  MAX_RUN  = 8'd255;
  localparam logic [30:0] NUM_MAX  = 31'h7FFF_FFFF;
  localparam logic [15:0] POS_MAX  = 16'hFFFF;
  localparam logic [4:0]  KW_ALL   = 5'h1F;
  localparam int          KW_COUNT = 5;
  localparam int          FQ_DEPTH = 4;
  localparam int          FQ_AW    = 2;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_IDENT,
    MODE_COMMENT,
    MODE_HELD
  } scan_mode_t;

  typedef enum logic [2:0] {
    TOK_NUMBER     = 3'd0,
    TOK_IDENT      = 3'd1,
    TOK_KEYWORD    = 3'd2,
    TOK_ARITH      = 3'd3,
    TOK_COMPARISON = 3'd4,
    TOK_PUNCT      = 3'd5,
    TOK_END        = 3'd6,
    TOK_ERROR      = 3'd7
  } token_kind_t;

  typedef enum logic [2:0] {
    KW_VAR   = 3'd0,
    KW_PRINT = 3'd1,
    KW_IF    = 3'd2,
    KW_ELSE  = 3'd3,
    KW_WHILE = 3'd4,
    KW_NONE  = 3'd5
  } kw_code_t;

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_END  = 1'b1
  } op_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [2:0]  keyword_code;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [7:0]  token_length;
    logic [7:0]  first_char;
    logic [7:0]  second_char;
    logic [30:0] number_value;
    logic        last_result;
  } token_t;

  // Keyword spelling, first character in element 0, zero padded.
  typedef logic [0:7][7:0] kw_text_t;

  function automatic kw_text_t kw_text(input logic [2:0] k);
    kw_text_t t;
    unique case (k)
      KW_VAR:   t = "variable";
      KW_PRINT: t = "afficher";
      KW_IF:    t = {"si", 48'h0};
      KW_ELSE:  t = {"sinon", 24'h0};
      KW_WHILE: t = {"tantque", 8'h0};
      default:  t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] kw_len(input logic [2:0] k);
    logic [7:0] n;
    unique case (k)
      KW_VAR:   n = 8'd8;
      KW_PRINT: n = 8'd8;
      KW_IF:    n = 8'd2;
      KW_ELSE:  n = 8'd5;
      KW_WHILE: n = 8'd7;
      default:  n = 8'd0;
    endcase
    return n;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_ident_char(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == "_");
  endfunction

  // Drop keyword candidates whose character at pos differs from c.
  function automatic logic [4:0] kw_filter(input logic [4:0] cand, input logic [7:0] pos,
                                           input logic [7:0] c);
    logic [4:0] res;
    kw_text_t   txt;
    res = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      txt = kw_text(3'(k));
      if (cand[k] && (pos < kw_len(3'(k))) && (txt[pos[2:0]] == c)) begin
        res[k] = 1'b1;
      end
    end
    return res;
  endfunction

  // Times ten plus the digit, saturating.
  function automatic logic [30:0] acc_digit(input logic [30:0] acc, input logic [7:0] c);
    logic [34:0] v;
    v = ({4'b0, acc} * 35'd10) + 35'(c[3:0]);
    return (v > 35'(NUM_MAX)) ? NUM_MAX : v[30:0];
  endfunction

endpackage

FILE: rtl/source_text_tokenizer.sv
// Source text tokenizer: scanner state, token build and a small result queue.
//
// Usage:
//   Input beats carry one source byte (operation = char) or an end-of-text
//   marker (operation = end). Each beat yields zero, one or two tokens on the
//   output channel; the last token caused by a beat has last_result set.
//   A number, identifier or single '<', '>', '=', '!' is reported when the
//   first byte that does not extend it arrives, or at end of text.
//   End of text flushes any pending token, sends the end token and returns
//   the scanner to its reset state so a new text may follow.
// A token is written into the result queue when the beat that completes it
//   is accepted, and is offered on out_valid once it reaches the queue head.
// Throughput: one input beat per cycle while in_stall is low. Every byte is
//   handled in one pass of compares and a times-ten accumulate between the
//   scanner registers and a four-entry result queue. Beats that make two
//   tokens need two pops, so the queue drain sets the rate in bursts of them.
// Stall: in_stall rises while the queue holds more than two tokens; a
//   stalled output simply holds the head token and the queue fills.
// Reset: synchronous, active low; empties the queue, sets line and column
//   to 1 and puts the scanner in idle.
module source_text_tokenizer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  stt_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output stt_pkg::token_t   out_data
);

  // Scanner state
  stt_pkg::scan_mode_t mode_r, mode_nxt;
  logic [7:0]  run_r, run_nxt;
  logic [30:0] acc_r, acc_nxt;
  logic [4:0]  cand_r, cand_nxt;
  logic [15:0] line_r, line_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] tline_r, tline_nxt;
  logic [15:0] tcol_r, tcol_nxt;
  logic [7:0]  held_r, held_nxt;

  // Result queue
  stt_pkg::token_t fifo_r [stt_pkg::FQ_DEPTH];
  logic [stt_pkg::FQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [stt_pkg::FQ_AW:0]   cnt_r;

  logic       accept, pop, is_end, is_char;
  logic [7:0] c;
  logic [15:0] col_inc, line_inc;

  logic num_cont, id_cont, held_pair, do_idle, do_flush, pair_go;
  logic flush_vld, idle_emits;
  stt_pkg::token_t flush_tok, idle_tok, pair_tok, end_tok;
  stt_pkg::token_t tok0, tok1;
  logic [1:0] tok_n;

  assign accept  = in_valid && !in_stall;
  assign pop     = out_valid && !out_stall;
  assign c       = in_data.ch;
  assign is_end  = (in_data.operation == stt_pkg::OP_END);
  assign is_char = !is_end;

  assign col_inc  = (col_r == stt_pkg::POS_MAX) ? col_r : col_r + 16'd1;
  assign line_inc = (line_r == stt_pkg::POS_MAX) ? line_r : line_r + 16'd1;

  // Which path this byte takes through the scanner
  assign num_cont  = stt_pkg::is_digit(c) && (run_r < stt_pkg::MAX_RUN);
  assign id_cont   = stt_pkg::is_ident_char(c) && (run_r < stt_pkg::MAX_RUN);
  assign held_pair = (c == "=");

  always_comb begin
    unique case (mode_r)
      stt_pkg::MODE_IDLE:    do_idle = 1'b1;
      stt_pkg::MODE_COMMENT: do_idle = (c == "\n");
      stt_pkg::MODE_NUMBER:  do_idle = !num_cont;
      stt_pkg::MODE_IDENT:   do_idle = !id_cont;
      stt_pkg::MODE_HELD:    do_idle = !held_pair;
      default:               do_idle = 1'b1;
    endcase
  end

  // A pending token is reported before a breaking byte and at end of text
  assign do_flush = is_end || (is_char && do_idle);
  assign pair_go  = is_char && (mode_r == stt_pkg::MODE_HELD) && held_pair;

  // Token left pending in the scanner
  always_comb begin
    flush_tok              = '0;
    flush_tok.keyword_code = stt_pkg::KW_NONE;
    flush_tok.start_line   = tline_r;
    flush_tok.start_column = tcol_r;
    flush_tok.first_char   = held_r;
    flush_vld              = 1'b1;
    unique case (mode_r)
      stt_pkg::MODE_NUMBER: begin
        flush_tok.token_kind   = stt_pkg::TOK_NUMBER;
        flush_tok.token_length = run_r;
        flush_tok.number_value = acc_r;
      end
      stt_pkg::MODE_IDENT: begin
        flush_tok.token_kind   = stt_pkg::TOK_IDENT;
        flush_tok.token_length = run_r;
        // Lowest-numbered keyword that still matches and is complete wins
        for (int k = stt_pkg::KW_COUNT - 1; k >= 0; k--) begin
          if (cand_r[k] && (run_r == stt_pkg::kw_len(3'(k)))) begin
            flush_tok.token_kind   = stt_pkg::TOK_KEYWORD;
            flush_tok.keyword_code = 3'(k);
          end
        end
      end
      stt_pkg::MODE_HELD: begin
        flush_tok.token_length = 8'd1;
        if ((held_r == "<") || (held_r == ">")) begin
          flush_tok.token_kind = stt_pkg::TOK_COMPARISON;
        end else if (held_r == "=") begin
          flush_tok.token_kind = stt_pkg::TOK_PUNCT;
        end else begin
          // lone '!'
          flush_tok.token_kind = stt_pkg::TOK_ERROR;
        end
      end
      default: flush_vld = 1'b0;
    endcase
  end

  // Single-character token started by a byte in idle
  always_comb begin
    idle_tok              = '0;
    idle_tok.keyword_code = stt_pkg::KW_NONE;
    idle_tok.start_line   = line_r;
    idle_tok.start_column = col_r;
    idle_tok.token_length = 8'd1;
    idle_tok.first_char   = c;
    idle_tok.token_kind   = stt_pkg::TOK_ERROR;
    if ((c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "%")) begin
      idle_tok.token_kind = stt_pkg::TOK_ARITH;
    end else if ((c == "(") || (c == ")") || (c == "{") || (c == "}") || (c == ";")) begin
      idle_tok.token_kind = stt_pkg::TOK_PUNCT;
    end
    idle_emits = !((c == " ") || (c == "\t") || (c == "\n") || (c == "#") ||
                   stt_pkg::is_digit(c) || stt_pkg::is_alpha(c) || (c == "_") ||
                   (c == "=") || (c == "!") || (c == "<") || (c == ">"));
  end

  // Two-character comparison and end token
  always_comb begin
    pair_tok              = '0;
    pair_tok.token_kind   = stt_pkg::TOK_COMPARISON;
    pair_tok.keyword_code = stt_pkg::KW_NONE;
    pair_tok.start_line   = tline_r;
    pair_tok.start_column = tcol_r;
    pair_tok.token_length = 8'd2;
    pair_tok.first_char   = held_r;
    pair_tok.second_char  = c;

    end_tok              = '0;
    end_tok.token_kind   = stt_pkg::TOK_END;
    end_tok.keyword_code = stt_pkg::KW_NONE;
  end

  // Output block: order the tokens of this beat into two slots
  always_comb begin
    tok0  = '0;
    tok1  = '0;
    tok_n = 2'd0;
    if (do_flush && flush_vld) begin
      tok0  = flush_tok;
      tok_n = 2'd1;
    end
    if (pair_go) begin
      tok0  = pair_tok;
      tok_n = 2'd1;
    end
    if (is_char && do_idle && idle_emits) begin
      if (tok_n == 2'd0) begin
        tok0 = idle_tok;
      end else begin
        tok1 = idle_tok;
      end
      tok_n = tok_n + 2'd1;
    end
    if (is_end) begin
      if (tok_n == 2'd0) begin
        tok0 = end_tok;
      end else begin
        tok1 = end_tok;
      end
      tok_n = tok_n + 2'd1;
    end
    // Mark the last token of the beat
    if (tok_n == 2'd2) begin
      tok1.last_result = 1'b1;
    end else begin
      tok0.last_result = 1'b1;
    end
  end

  // Next-state block
  always_comb begin
    mode_nxt  = mode_r;
    run_nxt   = run_r;
    acc_nxt   = acc_r;
    cand_nxt  = cand_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    tline_nxt = tline_r;
    tcol_nxt  = tcol_r;
    held_nxt  = held_r;
    if (is_end) begin
      // Back to reset values for the next text
      mode_nxt  = stt_pkg::MODE_IDLE;
      run_nxt   = 8'd0;
      acc_nxt   = '0;
      cand_nxt  = stt_pkg::KW_ALL;
      line_nxt  = 16'd1;
      col_nxt   = 16'd1;
      tline_nxt = 16'd1;
      tcol_nxt  = 16'd1;
      held_nxt  = 8'd0;
    end else if (do_idle) begin
      mode_nxt = stt_pkg::MODE_IDLE;
      run_nxt  = 8'd0;
      acc_nxt  = '0;
      cand_nxt = stt_pkg::KW_ALL;
      if ((c == " ") || (c == "\t")) begin
        col_nxt = col_inc;
      end else if (c == "\n") begin
        line_nxt = line_inc;
        col_nxt  = 16'd1;
      end else if (c == "#") begin
        mode_nxt = stt_pkg::MODE_COMMENT;
      end else begin
        // Every other byte starts a token here
        tline_nxt = line_r;
        tcol_nxt  = col_r;
        col_nxt   = col_inc;
        if (stt_pkg::is_digit(c)) begin
          mode_nxt = stt_pkg::MODE_NUMBER;
          held_nxt = c;
          run_nxt  = 8'd1;
          acc_nxt  = stt_pkg::acc_digit('0, c);
        end else if (stt_pkg::is_alpha(c) || (c == "_")) begin
          mode_nxt = stt_pkg::MODE_IDENT;
          held_nxt = c;
          run_nxt  = 8'd1;
          cand_nxt = stt_pkg::kw_filter(stt_pkg::KW_ALL, 8'd0, c);
        end else if ((c == "=") || (c == "!") || (c == "<") || (c == ">")) begin
          mode_nxt = stt_pkg::MODE_HELD;
          held_nxt = c;
        end
      end
    end else begin
      unique case (mode_r)
        stt_pkg::MODE_NUMBER: begin
          acc_nxt = stt_pkg::acc_digit(acc_r, c);
          run_nxt = run_r + 8'd1;
          col_nxt = col_inc;
        end
        stt_pkg::MODE_IDENT: begin
          cand_nxt = stt_pkg::kw_filter(cand_r, run_r, c);
          run_nxt  = run_r + 8'd1;
          col_nxt  = col_inc;
        end
        stt_pkg::MODE_HELD: begin
          mode_nxt = stt_pkg::MODE_IDLE;
          col_nxt  = col_inc;
        end
        default: begin
          // comment body: drop the byte
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= stt_pkg::MODE_IDLE;
      run_r   <= 8'd0;
      acc_r   <= '0;
      cand_r  <= stt_pkg::KW_ALL;
      line_r  <= 16'd1;
      col_r   <= 16'd1;
      tline_r <= 16'd1;
      tcol_r  <= 16'd1;
      held_r  <= 8'd0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      run_r   <= run_nxt;
      acc_r   <= acc_nxt;
      cand_r  <= cand_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      tline_r <= tline_nxt;
      tcol_r  <= tcol_nxt;
      held_r  <= held_nxt;
    end
  end

  // Result queue: up to two pushes and one pop per cycle
  assign in_stall  = (cnt_r > (stt_pkg::FQ_AW + 1)'(stt_pkg::FQ_DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_data  = fifo_r[rd_ptr_r];

  logic [stt_pkg::FQ_AW:0] push_n;
  assign push_n = accept ? (stt_pkg::FQ_AW + 1)'(tok_n) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + (stt_pkg::FQ_AW)'(push_n);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + (stt_pkg::FQ_AW)'(1);
      end
      cnt_r <= cnt_r + push_n - (stt_pkg::FQ_AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != '0) begin
      fifo_r[wr_ptr_r] <= tok0;
    end
    if (push_n == (stt_pkg::FQ_AW + 1)'(2)) begin
      fifo_r[wr_ptr_r + (stt_pkg::FQ_AW)'(1)] <= tok1;
    end
  end

endmodule

FILE: test/source_text_tokenizer_tb.sv
// Testbench for the source text tokenizer: directed table, random source text, token predictor.
`timescale 1ns / 100ps

module source_text_tokenizer_tb;
  import stt_pkg::*;

  // Control characters that the scanner treats as whitespace.
  localparam logic [7:0] LF  = 8'h0A;
  localparam logic [7:0] TAB = 8'h09;

  // Character pools for the random source text.
  localparam string LETTERS    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string DIGITS     = "0123456789";
  localparam string WORD_CHARS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  localparam string ARITH_OPS  = "+-*/%";
  localparam string PUNCT      = "(){};";
  localparam string CMP_LEAD   = "<>=!";
  localparam string BLANKS     = " \t\n";

  // Random beats per pacing phase, and the long receiver hold-off.
  localparam int PHASE_BEATS = 410;
  localparam int HOLD_AFTER  = 150;
  localparam int HOLD_CYCLES = 300;
  // Stretch of newlines, then of blanks, that makes no tokens at all.
  localparam int GAP_RUN     = 40;

  typedef struct {
    in_item_t item;
    bit       typed;
    token_t   tok;
  } dir_row_t;

  // Keyword spellings, indexed by their kw_code_t value.
  string kw_words [5] = '{"variable", "afficher", "si", "sinon", "tantque"};

  // Directed text. Rows marked typed carry a token that can be read off at a
  // glance; all other rows go through the predictor.
  dir_row_t dir_rows [25] = '{
    '{'{OP_CHAR, "+"}, 1'b1,
      '{TOK_ARITH, KW_NONE, 16'd1, 16'd1, 8'd1, "+", 8'd0, 31'd0, 1'b1}},
    '{'{OP_CHAR, 8'hFF}, 1'b1,
      '{TOK_ERROR, KW_NONE, 16'd1, 16'd2, 8'd1, 8'hFF, 8'd0, 31'd0, 1'b1}},
    '{'{OP_CHAR, 8'h00}, 1'b1,
      '{TOK_ERROR, KW_NONE, 16'd1, 16'd3, 8'd1, 8'h00, 8'd0, 31'd0, 1'b1}},
    '{'{OP_CHAR, "!"}, 1'b0, '0},   // lone bang, closed by the next letter
    '{'{OP_CHAR, "x"}, 1'b0, '0},
    '{'{OP_CHAR, "="}, 1'b0, '0},   // lone equals becomes punctuation
    '{'{OP_CHAR, ";"}, 1'b0, '0},
    '{'{OP_CHAR, "<"}, 1'b0, '0},   // two-character comparison
    '{'{OP_CHAR, "="}, 1'b0, '0},
    '{'{OP_CHAR, ">"}, 1'b0, '0},   // single comparison closed by a digit
    '{'{OP_CHAR, "9"}, 1'b0, '0},
    '{'{OP_CHAR, "#"}, 1'b0, '0},   // comment up to the newline
    '{'{OP_CHAR, "a"}, 1'b0, '0},
    '{'{OP_CHAR, LF},  1'b0, '0},
    '{'{OP_CHAR, "s"}, 1'b0, '0},   // shortest keyword
    '{'{OP_CHAR, "i"}, 1'b0, '0},
    '{'{OP_CHAR, " "}, 1'b0, '0},
    '{'{OP_CHAR, "1"}, 1'b0, '0},
    '{'{OP_CHAR, "2"}, 1'b0, '0},
    '{'{OP_END,  "2"}, 1'b0, '0},   // pending number, then end token
    '{'{OP_END,  8'h00}, 1'b1,
      '{TOK_END, KW_NONE, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 31'd0, 1'b1}},
    '{'{OP_CHAR, TAB}, 1'b0, '0},
    '{'{OP_CHAR, "!"}, 1'b0, '0},   // bang-equals
    '{'{OP_CHAR, "="}, 1'b0, '0},
    '{'{OP_END,  8'hFF}, 1'b0, '0}
  };

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_item_t in_data;
  logic     out_valid;
  logic     out_stall;
  token_t   out_data;

  // Pacing knobs: percent of cycles the sender idles and the receiver stalls.
  int idle_pct;
  int stall_pct;

  // Run bookkeeping.
  int err_count;
  int beats_sent;
  int tokens_checked;
  int kind_seen [8];
  bit hold_done;

  // Expected tokens in arrival order, and the beats of the fragment being sent.
  token_t   expected_tokens [$];
  token_t   beat_toks [$];
  in_item_t frag_q [$];

  // Predictor state.
  scan_mode_t  mode;
  logic [7:0]  run_len;
  logic [7:0]  lead_ch;
  logic [30:0] num_acc;
  logic [7:0]  word_buf [8];
  logic [15:0] cur_line;
  logic [15:0] cur_col;
  logic [15:0] tok_line;
  logic [15:0] tok_col;

  source_text_tokenizer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("source_text_tokenizer_tb NOT OK");
    $finish;
  end

  //--------------------------------------------------------------------------
  // Token predictor
  //--------------------------------------------------------------------------

  task automatic pred_reset();
    mode     = MODE_IDLE;
    run_len  = '0;
    num_acc  = '0;
    lead_ch  = '0;
    cur_line = 16'd1;
    cur_col  = 16'd1;
    tok_line = 16'd1;
    tok_col  = 16'd1;
  endtask

  // Queue one token for the current beat; a beat never makes more than two.
  task automatic add_token(input logic [2:0] kind, input logic [2:0] kw,
                           input logic [15:0] ln, input logic [15:0] cl,
                           input logic [7:0] len, input logic [7:0] c1,
                           input logic [7:0] c2, input logic [30:0] val);
    token_t t;
    t.token_kind   = kind;
    t.keyword_code = kw;
    t.start_line   = ln;
    t.start_column = cl;
    t.token_length = len;
    t.first_char   = c1;
    t.second_char  = c2;
    t.number_value = val;
    t.last_result  = 1'b0;
    if (beat_toks.size() < 2) beat_toks.push_back(t);
  endtask

  task automatic step_col();
    if (cur_col != POS_MAX) cur_col++;
  endtask

  task automatic mark_token();
    tok_line = cur_line;
    tok_col  = cur_col;
  endtask

  // An identifier is a keyword only when its whole text spells one.
  function automatic kw_code_t match_keyword(input logic [7:0] len);
    bit same;
    for (int k = 0; k < 5; k++) begin
      if (int'(len) == kw_words[k].len()) begin
        same = 1'b1;
        for (int i = 0; i < kw_words[k].len(); i++) begin
          if (word_buf[i] != kw_words[k][i]) same = 1'b0;
        end
        if (same) return kw_code_t'(k);
      end
    end
    return KW_NONE;
  endfunction

  // Report whatever token is still open and go back to idle.
  task automatic close_token();
    kw_code_t kw;
    case (mode)
      MODE_NUMBER: begin
        add_token(TOK_NUMBER, KW_NONE, tok_line, tok_col, run_len, lead_ch, 8'd0, num_acc);
      end
      MODE_IDENT: begin
        kw = match_keyword(run_len);
        add_token((kw == KW_NONE) ? TOK_IDENT : TOK_KEYWORD, kw, tok_line, tok_col,
                  run_len, lead_ch, 8'd0, 31'd0);
      end
      MODE_HELD: begin
        add_token((lead_ch == "<" || lead_ch == ">") ? TOK_COMPARISON :
                  (lead_ch == "=") ? TOK_PUNCT : TOK_ERROR,
                  KW_NONE, tok_line, tok_col, 8'd1, lead_ch, 8'd0, 31'd0);
      end
      default: ;
    endcase
    mode    = MODE_IDLE;
    run_len = '0;
    num_acc = '0;
  endtask

  // A byte seen with no token open.
  task automatic take_char(input logic [7:0] c);
    logic [2:0] kind;
    mode = MODE_IDLE;
    if (c == " " || c == TAB) begin
      step_col();
    end else if (c == LF) begin
      if (cur_line != POS_MAX) cur_line++;
      cur_col = 16'd1;
    end else if (c == "#") begin
      mode = MODE_COMMENT;
    end else if (c inside {["0":"9"]}) begin
      mark_token();
      mode    = MODE_NUMBER;
      lead_ch = c;
      run_len = 8'd1;
      num_acc = 31'(c - "0");
      step_col();
    end else if (c inside {["a":"z"], ["A":"Z"], "_"}) begin
      mark_token();
      mode        = MODE_IDENT;
      lead_ch     = c;
      run_len     = 8'd1;
      word_buf[0] = c;
      step_col();
    end else if (c inside {"=", "!", "<", ">"}) begin
      mark_token();
      mode    = MODE_HELD;
      lead_ch = c;
      step_col();
    end else begin
      mark_token();
      if (c inside {"+", "-", "*", "/", "%"}) kind = TOK_ARITH;
      else if (c inside {"(", ")", "{", "}", ";"}) kind = TOK_PUNCT;
      else kind = TOK_ERROR;
      add_token(kind, KW_NONE, tok_line, tok_col, 8'd1, c, 8'd0, 31'd0);
      step_col();
    end
  endtask

  // Work out the tokens that one accepted beat causes, into beat_toks.
  task automatic predict_tokens(input in_item_t it);
    logic [7:0] c;
    longint     grown;
    c = it.ch;
    beat_toks.delete();
    if (it.operation == OP_END) begin
      if (mode == MODE_COMMENT) mode = MODE_IDLE;
      close_token();
      add_token(TOK_END, KW_NONE, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 31'd0);
      pred_reset();
    end else begin
      case (mode)
        MODE_COMMENT: begin
          if (c == LF) take_char(c);
        end
        MODE_NUMBER: begin
          if ((c inside {["0":"9"]}) && run_len < MAX_RUN) begin
            grown   = longint'(num_acc) * 10 + longint'(c - "0");
            num_acc = (grown > longint'(NUM_MAX)) ? NUM_MAX : grown[30:0];
            run_len++;
            step_col();
          end else begin
            close_token();
            take_char(c);
          end
        end
        MODE_IDENT: begin
          if ((c inside {["a":"z"], ["A":"Z"], ["0":"9"], "_"}) && run_len < MAX_RUN) begin
            if (run_len < 8) word_buf[run_len[2:0]] = c;
            run_len++;
            step_col();
          end else begin
            close_token();
            take_char(c);
          end
        end
        MODE_HELD: begin
          if (c == "=") begin
            add_token(TOK_COMPARISON, KW_NONE, tok_line, tok_col, 8'd2, lead_ch, c, 31'd0);
            step_col();
            mode = MODE_IDLE;
          end else begin
            close_token();
            take_char(c);
          end
        end
        default: take_char(c);
      endcase
    end
    if (beat_toks.size() > 0) beat_toks[beat_toks.size() - 1].last_result = 1'b1;
  endtask

  //--------------------------------------------------------------------------
  // Checking
  //--------------------------------------------------------------------------

  // One line per mismatch; every miss counts.
  task automatic report_mismatch(input string what);
    err_count++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("token %0d: %s is %0d, want %0d",
                                tokens_checked, name, got, want));
    end
  endtask

  // Compare every token that leaves the block with the oldest expectation.
  always @(posedge clk) begin : token_check
    token_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch($sformatf("token %0d: kind %0d at %0d:%0d with none expected",
                                  tokens_checked, out_data.token_kind,
                                  out_data.start_line, out_data.start_column));
      end else begin
        want = expected_tokens.pop_front();
        check_field("token_kind",   32'(out_data.token_kind),   32'(want.token_kind));
        check_field("keyword_code", 32'(out_data.keyword_code), 32'(want.keyword_code));
        check_field("start_line",   32'(out_data.start_line),   32'(want.start_line));
        check_field("start_column", 32'(out_data.start_column), 32'(want.start_column));
        check_field("token_length", 32'(out_data.token_length), 32'(want.token_length));
        check_field("first_char",   32'(out_data.first_char),   32'(want.first_char));
        check_field("second_char",  32'(out_data.second_char),  32'(want.second_char));
        check_field("number_value", 32'(out_data.number_value), 32'(want.number_value));
        check_field("last_result",  32'(out_data.last_result),  32'(want.last_result));
      end
      kind_seen[out_data.token_kind]++;
      tokens_checked++;
    end
  end

  //--------------------------------------------------------------------------
  // Receiver: random stalls per phase, plus one long hold-off so the result
  // queue fills and the block has to stall its input.
  //--------------------------------------------------------------------------

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && tokens_checked >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  //--------------------------------------------------------------------------
  // Sender side
  //--------------------------------------------------------------------------

  // Offer one beat, starting at a falling edge, and return at the falling edge
  // after it is taken. Typed rows replace the prediction with their own token.
  task automatic send_beat(input in_item_t item, input bit typed, input token_t typed_tok);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    predict_tokens(item);
    if (typed) expected_tokens.push_back(typed_tok);
    else foreach (beat_toks[i]) expected_tokens.push_back(beat_toks[i]);
    beats_sent++;
    @(negedge clk);
  endtask

  // Drop valid, hold until every expected token is in, then set the new pace.
  task automatic drain_then_pace(input int idle, input int stall);
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    idle_pct  = idle;
    stall_pct = stall;
    @(negedge clk);
  endtask

  function automatic in_item_t char_beat(input logic [7:0] c);
    in_item_t it;
    it.operation = OP_CHAR;
    it.ch        = c;
    return it;
  endfunction

  function automatic logic [7:0] pick_from(input string pool);
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  task automatic push_char(input logic [7:0] c);
    frag_q.push_back(char_beat(c));
  endtask

  // Identifier or number that crosses the run limit, so it splits in two.
  task automatic make_long_run(input bit digits_only, input int len);
    push_char(digits_only ? pick_from(DIGITS) : pick_from(LETTERS));
    repeat (len - 1) push_char(digits_only ? pick_from(DIGITS) : pick_from(WORD_CHARS));
    push_char(" ");
  endtask

  // Mostly well-formed lexemes with random content, some noise and broken ones.
  task automatic make_fragment();
    int         pick;
    int         n;
    string      w;
    logic [7:0] c;
    in_item_t   eot;
    pick = $urandom_range(99);
    if (pick < 14) begin
      w = kw_words[$urandom_range(4)];
      for (int i = 0; i < w.len(); i++) push_char(w[i]);
    end else if (pick < 20) begin
      // near-miss keyword: cut short, case flipped or extended
      w = kw_words[$urandom_range(4)];
      n = $urandom_range(1, w.len());
      for (int i = 0; i < n; i++) begin
        c = w[i];
        if ($urandom_range(9) == 0) c = c ^ 8'h20;
        push_char(c);
      end
      if ($urandom_range(1)) push_char(pick_from(WORD_CHARS));
    end else if (pick < 34) begin
      push_char(pick_from(LETTERS));
      repeat ($urandom_range(0, 9)) push_char(pick_from(WORD_CHARS));
    end else if (pick < 46) begin
      // occasional long numbers to hit value saturation
      n = ($urandom_range(4) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 5);
      repeat (n) push_char(pick_from(DIGITS));
    end else if (pick < 53) begin
      push_char(pick_from(ARITH_OPS));
    end else if (pick < 63) begin
      push_char(pick_from(CMP_LEAD));
      if ($urandom_range(1)) push_char("=");
    end else if (pick < 69) begin
      push_char(pick_from(PUNCT));
    end else if (pick < 80) begin
      repeat ($urandom_range(1, 3)) push_char(pick_from(BLANKS));
    end else if (pick < 85) begin
      push_char("#");
      repeat ($urandom_range(0, 8)) begin
        c = 8'($urandom_range(255));
        if (c == LF) c = "x";
        push_char(c);
      end
      if ($urandom_range(3) != 0) push_char(LF);
    end else if (pick < 94) begin
      push_char(8'($urandom_range(255)));
    end else if (pick < 97) begin
      eot.operation = OP_END;
      eot.ch        = 8'($urandom_range(255));
      frag_q.push_back(eot);
    end else begin
      // number running straight into a word
      repeat ($urandom_range(1, 3)) push_char(pick_from(DIGITS));
      push_char(pick_from(LETTERS));
    end
    if ($urandom_range(1)) push_char(pick_from(BLANKS));
  endtask

  //--------------------------------------------------------------------------
  // Main sequence
  //--------------------------------------------------------------------------

  initial begin : main_seq
    int       phase_idle [4];
    int       phase_stall [4];
    int       phase_sent;
    in_item_t eot;
    // Pace per phase: free running, sender idling, receiver stalling, both.
    phase_idle  = '{0, 49, 0, 21};
    phase_stall = '{0, 0, 49, 21};
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    idle_pct  = 0;
    stall_pct = 0;
    pred_reset();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed text right out of reset.
    foreach (dir_rows[i]) send_beat(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].tok);
    drain_then_pace(0, 0);

    // Long silent stretches of newlines and blanks, with tokens on both sides.
    repeat (GAP_RUN) send_beat(char_beat(LF), 1'b0, '0);
    frag_q.delete();
    push_char("a");
    push_char("b");
    push_char("<");
    push_char(LF);
    push_char("7");
    frag_q.push_back(char_beat(" "));
    foreach (frag_q[i]) send_beat(frag_q[i], 1'b0, '0);
    repeat (GAP_RUN) send_beat(char_beat(" "), 1'b0, '0);
    frag_q.delete();
    push_char("q");
    push_char("1");
    push_char("+");
    push_char("!");
    foreach (frag_q[i]) send_beat(frag_q[i], 1'b0, '0);
    frag_q.delete();
    eot.operation = OP_END;
    eot.ch        = "z";
    send_beat(eot, 1'b0, '0);

    // Random text, one pacing phase at a time, draining in between.
    for (int ph = 0; ph < 4; ph++) begin
      drain_then_pace(phase_idle[ph], phase_stall[ph]);
      phase_sent = 0;
      if (ph == 1) make_long_run(1'b0, 256);
      if (ph == 3) make_long_run(1'b1, 257);
      while (phase_sent < PHASE_BEATS || frag_q.size() != 0) begin
        if (frag_q.size() == 0) make_fragment();
        send_beat(frag_q.pop_front(), 1'b0, '0);
        phase_sent++;
      end
    end

    // Close the last text so nothing stays pending, then drain.
    send_beat(eot, 1'b0, '0);
    drain_then_pace(0, 0);
    repeat (8) @(posedge clk);
    if (expected_tokens.size() != 0) begin
      report_mismatch($sformatf("%0d expected tokens never arrived", expected_tokens.size()));
    end

    $display("Run covered %0d input beats and %0d tokens, with split long runs and four paces.",
             beats_sent, tokens_checked);
    $display("Tokens by kind: num %0d id %0d kw %0d arith %0d cmp %0d punct %0d end %0d err %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
             kind_seen[4], kind_seen[5], kind_seen[6], kind_seen[7]);
    if (err_count == 0) begin
      $display("source_text_tokenizer_tb OK");
    end else begin
      $display("source_text_tokenizer_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/stt_pkg.sv
rtl/source_text_tokenizer.sv
test/source_text_tokenizer_tb.sv
